### rtl/assert_macros.svh
// Assertion helpers shared by checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds on a rising edge of clk outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

### rtl/smm_pkg.sv
package smm_pkg;

   localparam int DIM_W     = 3;
   localparam int IDX_W     = 3;
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PRODUCT_W = 35;

   localparam logic [DIM_W-1:0] DIM_RESET = 3'd6;

   typedef struct packed {
      logic wr_en;
      logic issue;
      logic first;
      logic last;
   } smm_cmd_type;

   typedef struct packed {
      logic mac_done;
   } smm_status_type;

endpackage

### rtl/square_matrix_multiply.sv
// Loading takes one request per cycle while in LOAD (req_ready is low otherwise), n*n requests
// for an n by n pair of matrices. Each product element then goes through operand reads,
// the read, product and accumulator registers of the multiply-accumulate pipeline, and one
// response, which is held until taken. Reset sets dim to 6 and clears the load count; the
// element stores are not cleared.
module square_matrix_multiply import smm_pkg::*; #(
   parameter int MAX_DIM = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [DATA_W-1:0]    req_a_value,
   input  logic signed [DATA_W-1:0]    req_b_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [PRODUCT_W-1:0] rsp_product_value,
   output logic [IDX_W-1:0]            rsp_row_index,
   output logic [IDX_W-1:0]            rsp_col_index,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic [DIM_W-1:0]            csr_wdata
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   smm_cmd_type       cmd;
   smm_status_type    status;
   logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;

   smm_ctl #(.MAX_DIM(MAX_DIM)) u_ctl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_col_index (rsp_col_index),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .wr_addr       (wr_addr),
      .rd_a_addr     (rd_a_addr),
      .rd_b_addr     (rd_b_addr)
   );

   smm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .wr_addr       (wr_addr),
      .rd_a_addr     (rd_a_addr),
      .rd_b_addr     (rd_b_addr),
      .wr_a_value    (req_a_value),
      .wr_b_value    (req_b_value),
      .product_value (rsp_product_value)
   );

endmodule

### rtl/smm_datapath.sv
module smm_datapath import smm_pkg::*; #(
   parameter int  MAX_DIM = 6,
   localparam int CELLS   = MAX_DIM * MAX_DIM,
   localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  smm_cmd_type                 cmd,
   output smm_status_type              status,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ADDR_W-1:0]           rd_a_addr,
   input  logic [ADDR_W-1:0]           rd_b_addr,
   input  logic signed [DATA_W-1:0]    wr_a_value,
   input  logic signed [DATA_W-1:0]    wr_b_value,
   output logic signed [PRODUCT_W-1:0] product_value
);

   logic signed [DATA_W-1:0]    left_mem  [CELLS];
   logic signed [DATA_W-1:0]    right_mem [CELLS];

   logic signed [DATA_W-1:0]    a_rd_ff;
   logic signed [DATA_W-1:0]    b_rd_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PRODUCT_W-1:0] acc_ff;

   logic rd_valid_ff, rd_first_ff, rd_last_ff;
   logic mul_valid_ff, mul_first_ff, mul_last_ff;
   logic done_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         left_mem[wr_addr]  <= wr_a_value;
         right_mem[wr_addr] <= wr_b_value;
      end
      if (cmd.issue) begin
         a_rd_ff <= left_mem[rd_a_addr];
         b_rd_ff <= right_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.issue;
         mul_valid_ff <= rd_valid_ff;
         done_ff      <= mul_valid_ff && mul_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff  <= cmd.first;
      rd_last_ff   <= cmd.last;
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      prod_ff      <= a_rd_ff * b_rd_ff;
      if (mul_valid_ff) begin
         if (mul_first_ff) begin
            acc_ff <= PRODUCT_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + PRODUCT_W'(prod_ff);
         end
      end
   end

   assign status.mac_done = done_ff;
   assign product_value   = acc_ff;

endmodule

### rtl/smm_ctl.sv
module smm_ctl import smm_pkg::*; #(
   parameter int  MAX_DIM = 6,
   localparam int CELLS   = MAX_DIM * MAX_DIM,
   localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_row_index,
   output logic [IDX_W-1:0]  rsp_col_index,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [DIM_W-1:0]  csr_wdata,
   output smm_cmd_type       cmd,
   input  smm_status_type    status,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [ADDR_W-1:0] rd_a_addr,
   output logic [ADDR_W-1:0] rd_b_addr
);

   localparam int CNT_W  = $clog2(CELLS + 1);

   typedef enum logic [1:0] {
      LOAD,
      ISSUE,
      DRAIN,
      RESULT
   } state_type;

   state_type         state_ff;
   logic [DIM_W-1:0]  dim_ff;
   logic [CNT_W-1:0]  load_count_ff;
   logic [IDX_W-1:0]  row_ff, col_ff, k_ff;
   logic [ADDR_W-1:0] row_base_ff, a_addr_ff, b_addr_ff;
   logic              rsp_valid_ff, last_ff;

   logic [DIM_W-1:0]  dim_n;
   logic [DIM_W-1:0]  n_last;
   logic [CNT_W-1:0]  total;

   always_comb begin
      dim_n = dim_ff;
      priority if (dim_ff == '0) begin
         dim_n = DIM_W'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         dim_n = DIM_W'(MAX_DIM);
      end
      n_last = dim_n - 1'b1;
      total  = CNT_W'(dim_n) * CNT_W'(dim_n);
   end

   assign req_ready = (state_ff == LOAD);

   assign cmd.wr_en = req_valid && req_ready;
   assign cmd.issue = (state_ff == ISSUE);
   assign cmd.first = (k_ff == '0);
   assign cmd.last  = (k_ff == n_last);

   assign wr_addr   = ADDR_W'(load_count_ff);
   assign rd_a_addr = a_addr_ff;
   assign rd_b_addr = b_addr_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_col_index = col_ff;
   assign rsp_last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= LOAD;
         dim_ff        <= DIM_RESET;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            LOAD: begin
               if (req_valid && (load_count_ff == CNT_W'(total - 1'b1))) begin
                  load_count_ff <= '0;
                  row_ff        <= '0;
                  col_ff        <= '0;
                  k_ff          <= '0;
                  row_base_ff   <= '0;
                  a_addr_ff     <= '0;
                  b_addr_ff     <= '0;
                  state_ff      <= ISSUE;
               end else if (csr_we) begin
                  load_count_ff <= '0;
               end else if (req_valid) begin
                  load_count_ff <= load_count_ff + 1'b1;
               end
            end
            ISSUE: begin
               a_addr_ff <= a_addr_ff + 1'b1;
               b_addr_ff <= b_addr_ff + ADDR_W'(dim_n);
               k_ff      <= k_ff + 1'b1;
               if (k_ff == n_last) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (status.mac_done) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= (row_ff == n_last) && (col_ff == n_last);
                  state_ff     <= RESULT;
               end
            end
            RESULT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  k_ff         <= '0;
                  if (last_ff) begin
                     state_ff <= LOAD;
                  end else begin
                     state_ff <= ISSUE;
                     if (col_ff == n_last) begin
                        col_ff      <= '0;
                        row_ff      <= row_ff + 1'b1;
                        row_base_ff <= row_base_ff + ADDR_W'(dim_n);
                        a_addr_ff   <= row_base_ff + ADDR_W'(dim_n);
                        b_addr_ff   <= '0;
                     end else begin
                        col_ff    <= col_ff + 1'b1;
                        a_addr_ff <= row_base_ff;
                        b_addr_ff <= ADDR_W'(col_ff + 1'b1);
                     end
                  end
               end
            end
         endcase
         if (csr_we) begin
            dim_ff <= csr_wdata;
         end
      end
   end

endmodule

### rtl/smm_checker.sv
`include "assert_macros.svh"

module smm_checker import smm_pkg::*; #(
   parameter int MAX_DIM = 6
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [PRODUCT_W-1:0] rsp_product_value,
   input logic [IDX_W-1:0]            rsp_row_index,
   input logic [IDX_W-1:0]            rsp_col_index,
   input logic                        rsp_last
);

   `ASSERT_CLK(rsp_hold_a, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_value)
         && $stable(rsp_row_index) && $stable(rsp_col_index) && $stable(rsp_last),
      "response changed while stalled")
   `ASSERT_NEVER(no_overlap_a, clock, reset, req_ready && rsp_valid, "request taken while a response is pending")
   `ASSERT_CLK(index_range_a, clock, reset,
      rsp_valid |-> (32'(rsp_row_index) < MAX_DIM) && (32'(rsp_col_index) < MAX_DIM),
      "response index out of range")
   `ASSERT_CLK(reload_a, clock, reset,
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid,
      "block not ready to load after last response")

endmodule

bind square_matrix_multiply smm_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);
